@@ hdl/mm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply package
// Shared constants, request and register codes, and the tag that travels
// with each multiply operand pair down the datapath.
// ----------------------------------------------------------------------------
package mm_pkg;

    // Matrix geometry.
    localparam int MAX_DIM = 8;
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * DIM_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;

    // Configuration registers.
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(MAX_DIM);

    // Arithmetic widths: Q16.16 operands, exact Q32.32 products.
    localparam int VALUE_W = 32;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = 2 * VALUE_W;
    localparam int ACC_W   = PROD_W + $clog2(MAX_DIM);

    typedef enum logic [1:0] {
        REQ_LOAD_A  = 2'd0,
        REQ_LOAD_B  = 2'd1,
        REQ_COMPUTE = 2'd2,
        REQ_UNUSED  = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_ROWS = 2'd0,
        CFG_A_COLS = 2'd1,
        CFG_B_ROWS = 2'd2,
        CFG_B_COLS = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    typedef enum logic {
        STATUS_OK       = 1'b0,
        STATUS_MISMATCH = 1'b1
    } status_t;

    // Control tag for one multiply step.
    typedef struct packed {
        logic             valid;
        logic             err;
        logic             first;
        logic             last_k;
        logic             last;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
    } tag_t;

    // Highest loop index for a dimension register: zero acts as one,
    // anything above the maximum acts as the maximum.
    function automatic logic [DIM_W-1:0] last_index(input logic [CFG_W-1:0] dim);
        logic [CFG_W-1:0] lim;
        if (dim == '0)
        begin
            lim = CFG_W'(1);
        end
        else if (dim > CFG_W'(MAX_DIM))
        begin
            lim = CFG_W'(MAX_DIM);
        end
        else
        begin
            lim = dim;
        end
        lim = lim - CFG_W'(1);
        return lim[DIM_W-1:0];
    endfunction

endpackage

@@ hdl/mm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module mm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/mm_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply sequencer
// Walks the row, column and inner indices of a compute run, drives the
// read addresses of both stores and issues a tag for each multiply step.
// ----------------------------------------------------------------------------
module mm_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [1:0]                  req_type,
    input  logic [mm_pkg::CFG_W-1:0]    a_rows,
    input  logic [mm_pkg::CFG_W-1:0]    a_cols,
    input  logic [mm_pkg::CFG_W-1:0]    b_rows,
    input  logic [mm_pkg::CFG_W-1:0]    b_cols,
    input  logic                        pipe_busy,
    output logic                        busy,
    output logic [mm_pkg::ADDR_W-1:0]   a_raddr,
    output logic [mm_pkg::ADDR_W-1:0]   b_raddr,
    output mm_pkg::tag_t                issue
);

    mm_pkg::state_t state_reg, state_next;
    logic [mm_pkg::DIM_W-1:0] i_reg, i_next;
    logic [mm_pkg::DIM_W-1:0] j_reg, j_next;
    logic [mm_pkg::DIM_W-1:0] k_reg, k_next;
    logic [mm_pkg::DIM_W-1:0] i_last, j_last, k_last;
    logic compute_req, mismatch, at_k_end, at_final;

    assign i_last = mm_pkg::last_index(a_rows);
    assign j_last = mm_pkg::last_index(b_cols);
    assign k_last = mm_pkg::last_index(a_cols);

    assign compute_req = start && (req_type == mm_pkg::REQ_COMPUTE);
    assign mismatch    = (a_cols != b_rows);
    assign at_k_end    = (k_reg == k_last);
    assign at_final    = at_k_end && (j_reg == j_last) && (i_reg == i_last);

    // State register and loop counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mm_pkg::ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mm_pkg::ST_IDLE:
            begin
                if (compute_req)
                begin
                    state_next = mismatch ? mm_pkg::ST_DRAIN : mm_pkg::ST_RUN;
                end
            end
            mm_pkg::ST_RUN:
            begin
                if (at_final)
                begin
                    state_next = mm_pkg::ST_DRAIN;
                end
            end
            mm_pkg::ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = mm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mm_pkg::ST_IDLE;
            end
        endcase
    end

    // Counter advance: inner index fastest, then column, then row.
    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        if (state_reg != mm_pkg::ST_RUN)
        begin
            i_next = '0;
            j_next = '0;
            k_next = '0;
        end
        else if (!at_k_end)
        begin
            k_next = k_reg + 1'b1;
        end
        else
        begin
            k_next = '0;
            if (j_reg != j_last)
            begin
                j_next = j_reg + 1'b1;
            end
            else
            begin
                j_next = '0;
                i_next = i_reg + 1'b1;
            end
        end
    end

    // Outputs: addresses, busy and the step tag.
    always_comb
    begin
        issue = '0;
        unique case (state_reg)
            mm_pkg::ST_IDLE:
            begin
                issue.valid  = compute_req && mismatch;
                issue.err    = 1'b1;
                issue.first  = 1'b1;
                issue.last_k = 1'b1;
                issue.last   = 1'b1;
            end
            mm_pkg::ST_RUN:
            begin
                issue.valid  = 1'b1;
                issue.first  = (k_reg == '0);
                issue.last_k = at_k_end;
                issue.last   = at_final;
                issue.row    = i_reg;
                issue.col    = j_reg;
            end
            mm_pkg::ST_DRAIN:
            begin
                issue = '0;
            end
            default:
            begin
                issue = '0;
            end
        endcase
    end

    assign busy    = (state_reg != mm_pkg::ST_IDLE);
    assign a_raddr = {i_reg, k_reg};
    assign b_raddr = {k_reg, j_reg};

    // An error word is issued once and the run then only drains.
    a_err_drain: assert property (@(posedge clk) disable iff (!rst_n)
        issue.valid && issue.err |=> state_reg == mm_pkg::ST_DRAIN)
        else $error("error word not followed by drain");

    // The final step of a run hands over to the drain state.
    a_final_drain: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mm_pkg::ST_RUN && at_final |=> state_reg == mm_pkg::ST_DRAIN)
        else $error("run did not end after final step");

    // Busy only drops once the datapath holds no more steps.
    a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(!pipe_busy))
        else $error("busy fell with steps in flight");

endmodule

@@ hdl/mm_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply MAC datapath
// Multiplies the two store read words, accumulates the exact products of
// one dot product, and registers the saturated Q16.16 result word.
// ----------------------------------------------------------------------------
module mm_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mm_pkg::tag_t                  issue,
    input  logic [mm_pkg::VALUE_W-1:0]    a_rdata,
    input  logic [mm_pkg::VALUE_W-1:0]    b_rdata,
    output logic                          pipe_busy,
    output logic                          strobe,
    output logic signed [mm_pkg::VALUE_W-1:0] prod_value,
    output logic [mm_pkg::DIM_W-1:0]      prod_row,
    output logic [mm_pkg::DIM_W-1:0]      prod_col,
    output logic                          status,
    output logic                          last
);

    localparam int SAT_LO = mm_pkg::FRAC_W + mm_pkg::VALUE_W - 1;

    mm_pkg::tag_t s1_reg, s2_reg;
    logic signed [mm_pkg::PROD_W-1:0] p_reg;
    logic signed [mm_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic signed [mm_pkg::ACC_W-1:0]  p_ext;
    logic [mm_pkg::ACC_W-1:SAT_LO]    sat_bits;
    logic signed [mm_pkg::VALUE_W-1:0] sat_value;
    logic strobe_reg;
    logic signed [mm_pkg::VALUE_W-1:0] value_reg;
    logic [mm_pkg::DIM_W-1:0] row_reg, col_reg;
    logic status_reg, last_reg;

    // Tag pipeline, aligned with read data and then with the product.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else
        begin
            s1_reg <= issue;
            s2_reg <= s1_reg;
        end
    end

    // Product register.
    always_ff @(posedge clk)
    begin
        p_reg <= signed'(a_rdata) * signed'(b_rdata);
    end

    // Accumulate; the first step of a dot product restarts the sum.
    assign p_ext    = mm_pkg::ACC_W'(p_reg);
    assign acc_next = (s2_reg.first ? '0 : acc_reg) + p_ext;

    always_ff @(posedge clk)
    begin
        if (s2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    // Drop the fraction bits (floor) and clamp to the signed word range.
    assign sat_bits = acc_next[mm_pkg::ACC_W-1:SAT_LO];
    always_comb
    begin
        if ((&sat_bits) || !(|sat_bits))
        begin
            sat_value = acc_next[SAT_LO:mm_pkg::FRAC_W];
        end
        else if (acc_next[mm_pkg::ACC_W-1])
        begin
            sat_value = {1'b1, {(mm_pkg::VALUE_W-1){1'b0}}};
        end
        else
        begin
            sat_value = {1'b0, {(mm_pkg::VALUE_W-1){1'b1}}};
        end
    end

    // Result word strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= s2_reg.valid && s2_reg.last_k;
        end
    end

    // Result word payload; an error word carries zeros.
    always_ff @(posedge clk)
    begin
        if (s2_reg.valid && s2_reg.last_k)
        begin
            value_reg  <= s2_reg.err ? '0 : sat_value;
            row_reg    <= s2_reg.err ? '0 : s2_reg.row;
            col_reg    <= s2_reg.err ? '0 : s2_reg.col;
            status_reg <= s2_reg.err ? mm_pkg::STATUS_MISMATCH : mm_pkg::STATUS_OK;
            last_reg   <= s2_reg.last;
        end
    end

    assign pipe_busy  = s1_reg.valid || s2_reg.valid;
    assign strobe     = strobe_reg;
    assign prod_value = value_reg;
    assign prod_row   = row_reg;
    assign prod_col   = col_reg;
    assign status     = status_reg;
    assign last       = last_reg;

    // A word is strobed only after the closing step of a dot product.
    a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(s2_reg.valid && s2_reg.last_k))
        else $error("result word without closing step");

    // An error word is zero-valued and closes the run.
    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && status_reg == mm_pkg::STATUS_MISMATCH
        |-> value_reg == '0 && last_reg)
        else $error("malformed error word");

    // Steps move through the tag pipeline without gaps or inventions.
    a_tag_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_reg.valid |=> s2_reg.valid)
        else $error("step lost in tag pipeline");

endmodule

@@ hdl/matrix_multiply.sv @@
`timescale 1ns / 1ps
// A load word is written straight into its store and leaves busy low. A compute
// word with mismatched sizes passes its error word through the tag pipeline to
// the result register; otherwise element (i,j) follows its last multiply through
// the store read, product and result registers. The shared MAC takes one
// multiply-accumulate per cycle, reading one word of each store per cycle.
// Reset clears the sequencer and strobes and sets all four sizes to 8; the
// stores are not cleared. The receiver cannot stall, so results never back up.
// ----------------------------------------------------------------------------
// Matrix multiply top level
// Holds the size registers, the two element stores, the sequencer and the
// MAC datapath for C = A * B on signed Q16.16 matrices.
// ----------------------------------------------------------------------------
module matrix_multiply (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        req_type,
    input  logic [mm_pkg::DIM_W-1:0]          elem_row,
    input  logic [mm_pkg::DIM_W-1:0]          elem_col,
    input  logic signed [mm_pkg::VALUE_W-1:0] elem_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mm_pkg::CFG_W-1:0]          cfg_data,
    output logic                              strobe,
    output logic signed [mm_pkg::VALUE_W-1:0] prod_value,
    output logic [mm_pkg::DIM_W-1:0]          prod_row,
    output logic [mm_pkg::DIM_W-1:0]          prod_col,
    output logic                              status,
    output logic                              last
);

    logic [mm_pkg::CFG_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic                     accept, we_a, we_b, pipe_busy;
    logic [mm_pkg::ADDR_W-1:0] waddr, a_raddr, b_raddr;
    logic [mm_pkg::VALUE_W-1:0] a_rdata, b_rdata;
    mm_pkg::tag_t             issue;

    // Size registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= mm_pkg::DIM_RESET;
            a_cols_reg <= mm_pkg::DIM_RESET;
            b_rows_reg <= mm_pkg::DIM_RESET;
            b_cols_reg <= mm_pkg::DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mm_pkg::CFG_A_ROWS: a_rows_reg <= cfg_data;
                mm_pkg::CFG_A_COLS: a_cols_reg <= cfg_data;
                mm_pkg::CFG_B_ROWS: b_rows_reg <= cfg_data;
                mm_pkg::CFG_B_COLS: b_cols_reg <= cfg_data;
                default:            a_rows_reg <= a_rows_reg;
            endcase
        end
    end

    // Load decode: indices are always within the stores.
    assign accept = start && !busy;
    assign we_a   = accept && (req_type == mm_pkg::REQ_LOAD_A);
    assign we_b   = accept && (req_type == mm_pkg::REQ_LOAD_B);
    assign waddr  = {elem_row, elem_col};

    // Element stores.
    mm_ram #(
        .WIDTH (mm_pkg::VALUE_W),
        .DEPTH (mm_pkg::DEPTH)
    ) u_left_store (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (elem_value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mm_ram #(
        .WIDTH (mm_pkg::VALUE_W),
        .DEPTH (mm_pkg::DEPTH)
    ) u_right_store (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (elem_value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // Index sequencer.
    mm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_type  (req_type),
        .a_rows    (a_rows_reg),
        .a_cols    (a_cols_reg),
        .b_rows    (b_rows_reg),
        .b_cols    (b_cols_reg),
        .pipe_busy (pipe_busy),
        .busy      (busy),
        .a_raddr   (a_raddr),
        .b_raddr   (b_raddr),
        .issue     (issue)
    );

    // Multiply-accumulate datapath.
    mm_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (issue),
        .a_rdata    (a_rdata),
        .b_rdata    (b_rdata),
        .pipe_busy  (pipe_busy),
        .strobe     (strobe),
        .prod_value (prod_value),
        .prod_row   (prod_row),
        .prod_col   (prod_col),
        .status     (status),
        .last       (last)
    );

endmodule
